// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the slot cache datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define LPSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Antecedent implies consequent in the next cycle
`define LPSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

// ----- hw/rtl/lpsc_pkg.sv -----
// Shared types and constants of the plan slot cache
package lpsc_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SIZE_W     = 31;
   localparam int STAMP_W    = 64;
   localparam int SLOT_OUT_W = 3;

   typedef struct packed {
      logic [SIZE_W-1:0] transform_size;
      logic              direction;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  build_plan;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_full;
   } dp_status_type;

endpackage

// ----- hw/rtl/lru_plan_slot_cache.sv -----
// A transaction is captured, then scanned one slot per cycle for key and
// stamp over all SLOT_COUNT slots, then committed once the result register
// is free; a new transaction is accepted only after the last one commits.
// A pending result may wait while the next transaction is scanned.
// Reset (synchronous, active high) clears all keys, plans, stamps and the
// use counter at once; no transaction is accepted during reset.
module lru_plan_slot_cache (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpsc_pkg::rsp_type rsp_data
);
   import lpsc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer
   lpsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Slot storage and scan
   lpsc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/lpsc_datapath.sv -----
// Slot storage, sequential key/stamp scan and result register
`include "assert_macros.svh"

module lpsc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  lpsc_pkg::req_type     req_data,
   input  lpsc_pkg::ctrl_cmd_type cmd,
   output lpsc_pkg::dp_status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lpsc_pkg::rsp_type     rsp_data
);
   import lpsc_pkg::*;

   // Slot state
   logic [SIZE_W-1:0]  key_size_ff      [SLOT_COUNT];
   logic               key_direction_ff [SLOT_COUNT];
   logic               plan_present_ff  [SLOT_COUNT];
   logic [STAMP_W-1:0] stamp_ff         [SLOT_COUNT];
   logic [STAMP_W-1:0] use_counter_ff;

   // Transaction and scan state
   req_type            req_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic               hit_ff;
   logic [SLOT_W-1:0]  match_idx_ff;
   logic [SLOT_W-1:0]  min_idx_ff;
   logic [STAMP_W-1:0] min_stamp_ff;

   // Result register
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               match;
   logic               smaller;
   logic [SLOT_W-1:0]  pick;
   logic               build;
   logic [SLOT_W+SLOT_OUT_W-1:0] pick_ext;

   // Compare the scanned slot against the request and the running minimum
   assign match   = (key_size_ff[idx_ff] == req_ff.transform_size) &&
                    (key_direction_ff[idx_ff] == req_ff.direction);
   assign smaller = (idx_ff == '0) || (stamp_ff[idx_ff] < min_stamp_ff);

   // Choose the serving slot
   assign pick     = hit_ff ? match_idx_ff : min_idx_ff;
   assign build    = hit_ff ? !plan_present_ff[pick] : 1'b1;
   assign pick_ext = (SLOT_W+SLOT_OUT_W)'(pick);

   assign status.scan_last = (idx_ff == SLOT_W'(SLOT_COUNT - 1));
   assign status.rsp_full  = rsp_valid_ff && rsp_stall;

   // Latch the transaction and walk the slots
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.step) begin
         if (match && !hit_ff) begin
            hit_ff       <= 1'b1;
            match_idx_ff <= idx_ff;
         end
         if (smaller) begin
            min_stamp_ff <= stamp_ff[idx_ff];
            min_idx_ff   <= idx_ff;
         end
         if (!status.scan_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // Update the serving slot and the use counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            key_size_ff[i]      <= '0;
            key_direction_ff[i] <= 1'b0;
            plan_present_ff[i]  <= 1'b0;
            stamp_ff[i]         <= '0;
         end
         use_counter_ff <= '0;
      end else if (cmd.commit) begin
         if (!hit_ff) begin
            key_size_ff[pick]      <= req_ff.transform_size;
            key_direction_ff[pick] <= req_ff.direction;
         end
         plan_present_ff[pick] <= 1'b1;
         stamp_ff[pick]        <= use_counter_ff;
         use_counter_ff        <= use_counter_ff + 1'b1;
      end
   end

   // Load the result register, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.hit        <= hit_ff;
         rsp_ff.slot       <= pick_ext[SLOT_OUT_W-1:0];
         rsp_ff.build_plan <= build;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LPSC_ASSERT_IMP(a_commit_room, clock, reset, cmd.commit, !status.rsp_full)
   `LPSC_ASSERT_NXT(a_counter_step, clock, reset, cmd.commit,
                    use_counter_ff == $past(use_counter_ff) + 1'b1)
   `LPSC_ASSERT_IMP(a_miss_builds, clock, reset, rsp_valid_ff && !rsp_ff.hit,
                    rsp_ff.build_plan)

endmodule

// ----- hw/rtl/lpsc_ctrl.sv -----
// Sequencer that steps a transaction through capture, scan and commit
module lpsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output lpsc_pkg::ctrl_cmd_type  cmd,
   input  lpsc_pkg::dp_status_type status
);
   import lpsc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      req_stall_in;

   // Decode next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!status.rsp_full) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      req_stall_in = (state_in != ST_IDLE);
   end

   // Hold state and stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

endmodule

// ----- tb/tb.sv -----
// Testbench for the LRU plan slot cache: queued requests, a mirror of the slots, result checks
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpsc_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 277;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   lru_plan_slot_cache uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Requests not yet driven and results not yet returned
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int quiet_cycles   = 0;
   // Requests presented by the driver and requests accepted by the block
   int sent_count     = 0;
   int taken_count    = 0;

   // Mirror of the slot table
   logic [SIZE_W-1:0]  slot_size    [SLOT_COUNT] = '{default: '0};
   logic               slot_dir     [SLOT_COUNT] = '{default: 1'b0};
   logic               slot_planned [SLOT_COUNT] = '{default: 1'b0};
   logic [STAMP_W-1:0] slot_stamp   [SLOT_COUNT] = '{default: '0};
   logic [STAMP_W-1:0] use_count = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Look up one request in the mirror, update it, and return the expected result
   function automatic rsp_type serve_request(input req_type q);
      int      pick;
      bit      found;
      bit      need_build;
      rsp_type r;
      found = 1'b0;
      pick  = 0;
      // lowest matching slot wins
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!found && slot_size[i] == q.transform_size && slot_dir[i] == q.direction) begin
            found = 1'b1;
            pick  = i;
         end
      end
      if (found) begin
         need_build = !slot_planned[pick];
      end else begin
         // evict the oldest stamp, lowest index on ties
         pick = 0;
         for (int i = 1; i < SLOT_COUNT; i++) begin
            if (slot_stamp[i] < slot_stamp[pick]) pick = i;
         end
         slot_size[pick] = q.transform_size;
         slot_dir[pick]  = q.direction;
         need_build      = 1'b1;
      end
      slot_planned[pick] = 1'b1;
      slot_stamp[pick]   = use_count;
      use_count          = use_count + 1'b1;
      r.hit        = found;
      r.slot       = SLOT_OUT_W'(pick);
      r.build_plan = need_build;
      return r;
   endfunction

   task report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   function void add_req(input logic [SIZE_W-1:0] size, input logic dir);
      req_type item;
      item.transform_size = size;
      item.direction      = dir;
      pending_reqs.push_back(item);
   endfunction

   // Fill one phase: mostly a small key pool (hits and evictions), some fully random keys
   task automatic queue_random_phase(input int count);
      req_type pool[$];
      req_type item;
      int      pool_n;
      pool_n = $urandom_range(6, 14);
      repeat (pool_n) begin
         case ($urandom_range(3))
            0:       item.transform_size = SIZE_W'($urandom_range(15));
            1:       item.transform_size = '1;
            default: item.transform_size = SIZE_W'($urandom());
         endcase
         item.direction = 1'($urandom_range(1));
         pool.push_back(item);
      end
      repeat (count) begin
         if ($urandom_range(99) < 75) begin
            item = pool[$urandom_range(pool.size() - 1)];
         end else begin
            item.transform_size = SIZE_W'($urandom());
            item.direction      = 1'($urandom_range(1));
         end
         pending_reqs.push_back(item);
      end
   endtask

   // Hold until every request is sent and every result is back
   task wait_drained;
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
   endtask

   // Driver: present requests and receiver stalls at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (taken_count == sent_count) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
            sent_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      rsp_type want;
      bit      moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(serve_request(req_data));
            taken_count++;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("result %h with no transaction pending", rsp_data));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.hit !== want.hit)
                  report_mismatch($sformatf("hit: got %b, expected %b", rsp_data.hit, want.hit));
               if (rsp_data.slot !== want.slot)
                  report_mismatch($sformatf("slot: got %0d, expected %0d",
                                            rsp_data.slot, want.slot));
               if (rsp_data.build_plan !== want.build_plan)
                  report_mismatch($sformatf("build_plan: got %b, expected %b",
                                            rsp_data.build_plan, want.build_plan));
            end
         end
         // watchdog on cycles with no transaction on either side
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      send_gap_pct   = 8;
      recv_stall_pct = 72;

      // Directed: reset keys, duplicate matches, extremes, LRU cycling
      add_req(31'd0, 1'b0);            // hits slot 0 of the reset keys, needs a build
      add_req(31'd0, 1'b0);            // hit, plan present
      add_req(31'd0, 1'b1);            // miss, stamps of slots 1-7 tie, slot 1 evicted
      add_req(31'd0, 1'b0);            // several reset slots still match
      add_req(31'h7FFFFFFF, 1'b1);
      add_req(31'h7FFFFFFF, 1'b0);
      add_req(31'h7FFFFFFF, 1'b1);
      add_req(31'h2AAAAAAA, 1'b0);
      add_req(31'h55555555, 1'b1);
      for (int k = 1; k <= 9; k++) add_req(SIZE_W'(k), k[0]);
      add_req(31'd1, 1'b1);
      add_req(31'd2, 1'b0);
      add_req(31'h7FFFFFFF, 1'b0);
      add_req(31'd0, 1'b0);
      add_req(31'h55555555, 1'b1);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      wait_drained();

      queue_random_phase(PHASE_ITEMS);
      wait_drained();

      send_gap_pct   = 72;
      recv_stall_pct = 8;
      queue_random_phase(PHASE_ITEMS);
      wait_drained();

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      queue_random_phase(PHASE_ITEMS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lpsc_pkg.sv
hw/rtl/lpsc_datapath.sv
hw/rtl/lpsc_ctrl.sv
hw/rtl/lru_plan_slot_cache.sv
tb/tb.sv
